// ===== hw/rtl/pvc_pkg.sv =====
package pvc_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned PIX_OUT_W = 14;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_VIEW_HEIGHT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_WRAP_REJECT = 3'd7;

	// span limit is 0.9 of the view width: compare |dx|*10 against w*9
	localparam logic [35:0] WRAP_NUM = 36'd10;
	localparam logic [35:0] WRAP_DEN = 36'd9;

	typedef struct packed {
		logic load_in;
		logic diff;
		logic axis_y;
		logic mul_tf;
		logic pix;
		logic delta;
		logic sel_pt;
		logic end_pt;
		logic mul_clip;
		logic clip_y;
		logic div_start;
		logic apply;
		logic store;
		logic emit_load;
	} pvc_cmd_t;

	typedef struct packed {
		logic skip;
		logic x_out;
		logic y_out;
		logic dx_zero;
		logic dy_zero;
		logic div_done;
		logic wrap_hit;
	} pvc_sts_t;

endpackage

// ===== hw/rtl/pvc_div.sv =====
module pvc_div import pvc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [63:0] num,
	input  logic signed [31:0] den,
	output logic               busy,
	output logic               done,
	output logic signed [63:0] quo
);

	localparam int unsigned NW = 64;
	localparam int unsigned CW = $clog2(NW);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [NW-1:0] n_q;
	logic [31:0]   d_q;
	logic [31:0]   rem_q;
	logic [32:0]   trial;
	logic          fits;

	assign trial = {rem_q, n_q[NW-1]};
	assign fits  = trial >= {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(NW - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// restoring division on magnitudes, quotient bits shift in from the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63] ^ den[31];
			n_q   <= num[63] ? NW'(-num) : NW'(num);
			d_q   <= den[31] ? 32'(-den) : 32'(den);
			rem_q <= '0;
		end else if (busy_q) begin
			n_q   <= {n_q[NW-2:0], fits};
			rem_q <= fits ? 32'(trial - {1'b0, d_q}) : trial[31:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign quo  = neg_q ? -$signed(n_q) : $signed(n_q);

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("divider done without a run");
	a_zero_den: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> den != '0) else $error("divider started on zero divisor");

endmodule

// ===== hw/rtl/pvc_dp.sv =====
module pvc_dp import pvc_pkg::*; #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [63:0]           in_data,
	input  logic                  in_first,
	input  pvc_cmd_t              cmd,
	output pvc_sts_t              sts,
	output logic [55:0]           out_data
);

	localparam logic signed [65:0] PIX_MAX = 66'sd1073741823;
	localparam logic signed [65:0] PIX_MIN = -66'sd1073741824;

	logic [23:0]        scale_q;
	logic signed [31:0] off_x_q;
	logic signed [31:0] off_y_q;
	logic [12:0]        vw_q;
	logic [12:0]        vh_q;
	logic [12:0]        org_x_q;
	logic [12:0]        org_y_q;
	logic               wrap_q;

	logic signed [31:0] pt_x_q;
	logic signed [31:0] pt_y_q;
	logic               first_q;
	logic               had_q;
	logic signed [30:0] prev_px_q;
	logic signed [30:0] prev_py_q;
	logic               prev_valid_q;
	logic signed [30:0] x1_q;
	logic signed [30:0] y1_q;
	logic signed [30:0] x2_q;
	logic signed [30:0] y2_q;
	logic signed [32:0] diff_q;
	logic signed [65:0] prod_q;
	logic signed [31:0] dx_q;
	logic signed [31:0] dy_q;
	logic signed [63:0] cx_q;
	logic signed [63:0] cy_q;
	logic [12:0]        sx_q;
	logic [12:0]        sy_q;
	logic [12:0]        ex_q;
	logic [12:0]        ey_q;
	logic [55:0]        out_q;

	logic signed [63:0] w64;
	logic signed [63:0] h64;
	logic signed [63:0] xb64;
	logic signed [63:0] yb64;
	logic signed [32:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [65:0] shv;
	logic signed [30:0] pixv;
	logic [31:0]        adx;
	logic signed [63:0] quo;
	logic               div_busy;
	logic               div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q      <= 24'd65536;
			off_x_q      <= '0;
			off_y_q      <= '0;
			vw_q         <= 13'd1024;
			vh_q         <= 13'd1024;
			org_x_q      <= '0;
			org_y_q      <= '0;
			wrap_q       <= 1'b0;
			prev_px_q    <= '0;
			prev_py_q    <= '0;
			prev_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE:       scale_q <= cfg_data[23:0];
					REG_OFFSET_X:    off_x_q <= cfg_data;
					REG_OFFSET_Y:    off_y_q <= cfg_data;
					REG_VIEW_WIDTH:  vw_q    <= cfg_data[12:0];
					REG_VIEW_HEIGHT: vh_q    <= cfg_data[12:0];
					REG_ORIGIN_X:    org_x_q <= cfg_data[12:0];
					REG_ORIGIN_Y:    org_y_q <= cfg_data[12:0];
					REG_WRAP_REJECT: wrap_q  <= cfg_data[0];
					default: ;
				endcase
			end
			if (cmd.delta) begin
				prev_px_q    <= x2_q;
				prev_py_q    <= y2_q;
				prev_valid_q <= 1'b1;
			end
		end
	end

	assign w64  = $signed(64'(vw_q) << FRAC_BITS);
	assign h64  = $signed(64'(vh_q) << FRAC_BITS);
	assign xb64 = cx_q[63] ? 64'sd0 : w64;
	assign yb64 = cy_q[63] ? 64'sd0 : h64;

	// one shared multiplier: transform or clip numerator
	always_comb begin
		if (cmd.mul_clip && !cmd.clip_y) begin
			mul_a = {dy_q[31], dy_q};
			mul_b = 33'(xb64) - {{2{x1_q[30]}}, x1_q};
		end else if (cmd.mul_clip) begin
			mul_a = {dx_q[31], dx_q};
			mul_b = 33'(yb64) - {{2{y1_q[30]}}, y1_q};
		end else begin
			mul_a = diff_q;
			mul_b = $signed({9'd0, scale_q});
		end
	end

	assign shv = prod_q >>> 16;

	always_comb begin
		if (shv > PIX_MAX)
			pixv = 31'(PIX_MAX);
		else if (shv < PIX_MIN)
			pixv = 31'(PIX_MIN);
		else
			pixv = 31'(shv);
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pt_x_q  <= in_data[31:0];
			pt_y_q  <= in_data[63:32];
			first_q <= in_first;
			had_q   <= prev_valid_q;
			x1_q    <= prev_px_q;
			y1_q    <= prev_py_q;
		end
		if (cmd.diff) begin
			if (cmd.axis_y)
				diff_q <= {pt_y_q[31], pt_y_q} - {off_y_q[31], off_y_q};
			else
				diff_q <= {pt_x_q[31], pt_x_q} - {off_x_q[31], off_x_q};
		end
		if (cmd.mul_tf || cmd.mul_clip)
			prod_q <= mul_a * mul_b;
		if (cmd.pix) begin
			if (cmd.axis_y)
				y2_q <= pixv;
			else
				x2_q <= pixv;
		end
		if (cmd.delta) begin
			dx_q <= 32'(x2_q) - 32'(x1_q);
			dy_q <= 32'(y2_q) - 32'(y1_q);
		end
		if (cmd.sel_pt) begin
			cx_q <= cmd.end_pt ? 64'(x2_q) : 64'(x1_q);
			cy_q <= cmd.end_pt ? 64'(y2_q) : 64'(y1_q);
		end
		if (cmd.apply) begin
			if (cmd.clip_y) begin
				cx_q <= 64'(x1_q) + quo;
				cy_q <= yb64;
			end else begin
				cx_q <= xb64;
				cy_q <= 64'(y1_q) + quo;
			end
		end
		if (cmd.store) begin
			if (cmd.end_pt) begin
				ex_q <= cx_q[FRAC_BITS +: 13];
				ey_q <= cy_q[FRAC_BITS +: 13];
			end else begin
				sx_q <= cx_q[FRAC_BITS +: 13];
				sy_q <= cy_q[FRAC_BITS +: 13];
			end
		end
		if (cmd.emit_load) begin
			out_q[13:0]  <= 14'(sx_q) + 14'(org_x_q);
			out_q[27:14] <= 14'(vh_q) - 14'(sy_q) + 14'(org_y_q);
			out_q[41:28] <= 14'(ex_q) + 14'(org_x_q);
			out_q[55:42] <= 14'(vh_q) - 14'(ey_q) + 14'(org_y_q);
		end
	end

	pvc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (prod_q[63:0]),
		.den    (cmd.clip_y ? dy_q : dx_q),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (quo)
	);

	assign adx = dx_q[31] ? 32'(-dx_q) : 32'(dx_q);

	assign sts.skip     = first_q || !had_q;
	assign sts.x_out    = cx_q < 64'sd0 || cx_q > w64;
	assign sts.y_out    = cy_q < 64'sd0 || cy_q > h64;
	assign sts.dx_zero  = dx_q == '0;
	assign sts.dy_zero  = dy_q == '0;
	assign sts.div_done = div_done && !div_busy;
	assign sts.wrap_hit = wrap_q && (36'(adx) * WRAP_NUM >= (36'(vw_q) << FRAC_BITS) * WRAP_DEN);

	assign out_data = out_q;

endmodule

// ===== hw/rtl/pvc_ctrl.sv =====
module pvc_ctrl import pvc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  pvc_sts_t sts,
	output pvc_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE, S_DIFF_X, S_MUL_X, S_PIX_X, S_DIFF_Y, S_MUL_Y, S_PIX_Y, S_DELTA,
		S_SEL, S_CHK_X, S_MUL_CX, S_DIV_CX, S_WAIT_CX, S_CHK_Y, S_MUL_CY,
		S_DIV_CY, S_WAIT_CY, S_CHK_FIN, S_EMIT
	} state_t;

	state_t state_q;
	logic   end_q;
	logic   out_valid_q;
	logic   emit_ok;

	assign emit_ok = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.end_pt   = end_q;
		case (state_q)
			S_IDLE:    cmd.load_in = in_valid;
			S_DIFF_X:  cmd.diff = 1'b1;
			S_MUL_X:   cmd.mul_tf = 1'b1;
			S_PIX_X:   cmd.pix = 1'b1;
			S_DIFF_Y: begin
				cmd.diff   = 1'b1;
				cmd.axis_y = 1'b1;
			end
			S_MUL_Y:   cmd.mul_tf = 1'b1;
			S_PIX_Y: begin
				cmd.pix    = 1'b1;
				cmd.axis_y = 1'b1;
			end
			S_DELTA:   cmd.delta = 1'b1;
			S_SEL:     cmd.sel_pt = 1'b1;
			S_MUL_CX:  cmd.mul_clip = 1'b1;
			S_DIV_CX:  cmd.div_start = 1'b1;
			S_WAIT_CX: cmd.apply = sts.div_done;
			S_MUL_CY: begin
				cmd.mul_clip = 1'b1;
				cmd.clip_y   = 1'b1;
			end
			S_DIV_CY: begin
				cmd.div_start = 1'b1;
				cmd.clip_y    = 1'b1;
			end
			S_WAIT_CY: begin
				cmd.apply  = sts.div_done;
				cmd.clip_y = 1'b1;
			end
			S_CHK_FIN: cmd.store = !sts.x_out;
			S_EMIT:    cmd.emit_load = emit_ok;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE:   if (in_valid) state_q <= S_DIFF_X;
				S_DIFF_X: state_q <= S_MUL_X;
				S_MUL_X:  state_q <= S_PIX_X;
				S_PIX_X:  state_q <= S_DIFF_Y;
				S_DIFF_Y: state_q <= S_MUL_Y;
				S_MUL_Y:  state_q <= S_PIX_Y;
				S_PIX_Y:  state_q <= S_DELTA;
				S_DELTA: begin
					end_q   <= 1'b0;
					state_q <= sts.skip ? S_IDLE : S_SEL;
				end
				S_SEL:    state_q <= S_CHK_X;
				S_CHK_X: begin
					if (!sts.x_out)
						state_q <= S_CHK_Y;
					else
						state_q <= sts.dx_zero ? S_IDLE : S_MUL_CX;
				end
				S_MUL_CX: state_q <= S_DIV_CX;
				S_DIV_CX: state_q <= S_WAIT_CX;
				S_WAIT_CX: if (sts.div_done) state_q <= S_CHK_Y;
				S_CHK_Y: begin
					if (!sts.y_out)
						state_q <= S_CHK_FIN;
					else
						state_q <= sts.dy_zero ? S_IDLE : S_MUL_CY;
				end
				S_MUL_CY: state_q <= S_DIV_CY;
				S_DIV_CY: state_q <= S_WAIT_CY;
				S_WAIT_CY: if (sts.div_done) state_q <= S_CHK_FIN;
				S_CHK_FIN: begin
					if (sts.x_out)
						state_q <= S_IDLE;
					else if (!end_q) begin
						end_q   <= 1'b1;
						state_q <= S_SEL;
					end else
						state_q <= sts.wrap_hit ? S_IDLE : S_EMIT;
				end
				S_EMIT: begin
					if (emit_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |=> out_valid_q) else $error("result register not loaded");
	a_div_x_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_start && !cmd.clip_y) |-> !sts.dx_zero) else $error("x division by zero");
	a_div_y_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_start && cmd.clip_y) |-> !sts.dy_zero) else $error("y division by zero");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit_load |-> (!out_valid_q || out_ready)) else $error("pending result overwritten");

endmodule

// ===== hw/rtl/polyline_viewport_clipper_core.sv =====
// per vertex: the transform steps (load, diff, multiply and pixel clamp for x and y, delta), then per clipped side
// a multiply, a divider start and a wait on the radix-2 divider, plus check states (select, x, y, final) per endpoint
// the block takes one vertex at a time, and each clipped side waits on the shared 64-step divider
// a finished segment waits in the output register while the next vertex is taken
// reset: arst_n clears control, the previous vertex and loads the register defaults
module polyline_viewport_clipper_core import pvc_pkg::*; #(
	parameter int unsigned FRAC_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [63:0]           s_axis_tdata,  // point_x, point_y
	input  logic                  s_axis_tuser,  // first_point
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [55:0]           m_axis_tdata,  // start_x, start_y, end_x, end_y
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	pvc_cmd_t cmd;
	pvc_sts_t sts;

	pvc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pvc_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_axis_tdata),
		.in_first  (s_axis_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import pvc_pkg::*;

	localparam int FRAC = 8;
	localparam int IDLE_LIMIT = 20000;
	localparam int SETTLE = 400;

	typedef struct packed {
		logic [13:0] end_y;
		logic [13:0] end_x;
		logic [13:0] start_y;
		logic [13:0] start_x;
	} segment_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [63:0]           s_axis_tdata = '0;  // point_x, point_y
	logic                  s_axis_tuser = 1'b0;  // first_point
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [55:0]           m_axis_tdata;  // start_x, start_y, end_x, end_y
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	polyline_viewport_clipper_core #(.FRAC_BITS(FRAC)) u_dut (.*);

	always #4 clk = ~clk;

	// shadow of the block's registers and vertex state
	logic [23:0] sh_scale;
	longint sh_off_x, sh_off_y, sh_width, sh_height, sh_org_x, sh_org_y;
	bit sh_wrap;
	longint last_px, last_py;
	bit last_valid;
	logic [31:0] last_map_x, last_map_y;

	segment_t expected_segs[$];
	int errors = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit quiet = 1'b0;
	int stall_left = 0;

	function automatic longint map_to_pixel(logic [31:0] p, longint off);
		longint r;
		r = ((longint'($signed(p)) - off) * longint'({40'd0, sh_scale})) >>> 16;
		if (r > 64'sd1073741823) r = 64'sd1073741823;
		if (r < -64'sd1073741824) r = -64'sd1073741824;
		return r;
	endfunction

	function automatic bit clip_point(input longint xa, ya, x1, y1, dx, dy, w, h,
			output longint xo, yo);
		longint x, y, xb, yb;
		x = xa;
		y = ya;
		if (xa < 0 || xa > w) begin
			xb = (xa < 0) ? 0 : w;
			if (dx == 0) return 1'b0;
			x = xb;
			y = y1 + (dy * (xb - x1)) / dx;
		end
		if (y < 0 || y > h) begin
			yb = (y < 0) ? 0 : h;
			if (dy == 0) return 1'b0;
			x = x1 + (dx * (yb - y1)) / dy;
			y = yb;
		end
		xo = x;
		yo = y;
		return 1'b1;
	endfunction

	task automatic predict_segment(logic [31:0] px, logic [31:0] py, bit first);
		longint x1, y1, x2, y2, dx, dy, w, h, xs, ys, xe, ye, adx;
		bit had;
		segment_t seg;
		x2 = map_to_pixel(px, sh_off_x);
		y2 = map_to_pixel(py, sh_off_y);
		x1 = last_px;
		y1 = last_py;
		had = last_valid;
		w = sh_width << FRAC;
		h = sh_height << FRAC;
		last_px = x2;
		last_py = y2;
		last_valid = 1'b1;
		if (first || !had) return;
		dx = x2 - x1;
		dy = y2 - y1;
		if (!clip_point(x1, y1, x1, y1, dx, dy, w, h, xs, ys)) return;
		if (xs < 0 || xs > w) return;
		if (!clip_point(x2, y2, x1, y1, dx, dy, w, h, xe, ye)) return;
		if (xe < 0 || xe > w) return;
		adx = (dx < 0) ? -dx : dx;
		if (sh_wrap && adx * 10 >= w * 9) return;
		seg.start_x = 14'((xs >>> FRAC) + sh_org_x);
		seg.start_y = 14'(sh_height - (ys >>> FRAC) + sh_org_y);
		seg.end_x = 14'((xe >>> FRAC) + sh_org_x);
		seg.end_y = 14'(sh_height - (ye >>> FRAC) + sh_org_y);
		expected_segs.push_back(seg);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SCALE:       sh_scale = val[23:0];
			REG_OFFSET_X:    sh_off_x = longint'($signed(val));
			REG_OFFSET_Y:    sh_off_y = longint'($signed(val));
			REG_VIEW_WIDTH:  sh_width = longint'(val[12:0]);
			REG_VIEW_HEIGHT: sh_height = longint'(val[12:0]);
			REG_ORIGIN_X:    sh_org_x = longint'(val[12:0]);
			REG_ORIGIN_Y:    sh_org_y = longint'(val[12:0]);
			REG_WRAP_REJECT: sh_wrap = val[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_point(logic [31:0] px, logic [31:0] py, bit first);
		if (!quiet && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {py, px};
		s_axis_tuser <= first;
		do @(posedge clk); while (!s_axis_tready);
		last_map_x = px;
		last_map_y = py;
		predict_segment(px, py, first);
	endtask

	// hold the sender until every segment is out, then let the block settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_segs.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] pick_coord(longint span, longint off, bit axis_y);
		longint target;
		if (sh_scale == 0 || $urandom_range(0, 9) == 0) return $urandom;
		if ($urandom_range(0, 12) == 0) return axis_y ? last_map_y : last_map_x;
		target = longint'($urandom_range(0, 32'(span * 512))) - span * 128;
		return 32'(off + (target <<< 16) / longint'({40'd0, sh_scale}));
	endfunction

	task automatic run_polylines(int count);
		int n, len;
		n = 0;
		while (n < count) begin
			len = $urandom_range(1, 10);
			for (int k = 0; k < len; k++) begin
				send_point(pick_coord(sh_width, sh_off_x, 1'b0),
					pick_coord(sh_height, sh_off_y, 1'b1),
					(k == 0) ? 1'b1 : ($urandom_range(0, 30) == 0));
				n++;
			end
		end
	endtask

	task automatic test_directed();
		send_point(32'(100 << 8), 32'(200 << 8), 1'b1);
		send_point(32'(512 << 8), 32'(700 << 8), 1'b0);
		send_point(32'(-100 << 8), 32'(300 << 8), 1'b0);
		send_point(32'(2000 << 8), 32'(300 << 8), 1'b0);
		send_point(32'(2000 << 8), 32'(5000 << 8), 1'b0);
		send_point(32'(500 << 8), 32'(-200 << 8), 1'b0);
		send_point(32'(600 << 8), 32'(-200 << 8), 1'b0);
		send_point(32'h7fffffff, 32'h7fffffff, 1'b0);
		send_point(32'h80000000, 32'h80000000, 1'b0);
		send_point(32'h0, 32'h0, 1'b1);
		send_point(32'(1024 << 8), 32'(1024 << 8), 1'b0);
		send_point(32'(300 << 8), 32'(300 << 8), 1'b0);
		send_point(32'hffffffff, 32'h0000ffff, 1'b1);
		send_point(32'(400 << 8), 32'(400 << 8), 1'b0);
		drain();
	endtask

	task automatic test_wrap_reject();
		write_reg(REG_WRAP_REJECT, 32'd1);
		send_point(32'(10 << 8), 32'(10 << 8), 1'b1);
		send_point(32'(1000 << 8), 32'(20 << 8), 1'b0);
		send_point(32'(100 << 8), 32'(30 << 8), 1'b0);
		send_point(32'(1021 << 8), 32'(40 << 8), 1'b0);
		drain();
		run_polylines(100);
		drain();
		write_reg(REG_VIEW_WIDTH, 32'd0);
		run_polylines(20);
		drain();
		write_reg(REG_WRAP_REJECT, 32'd0);
	endtask

	task automatic test_config_sweep();
		write_reg(REG_SCALE, 32'hffffff);
		write_reg(REG_OFFSET_X, 32'h7fffffff);
		write_reg(REG_OFFSET_Y, 32'h80000000);
		write_reg(REG_VIEW_WIDTH, 32'd8191);
		write_reg(REG_VIEW_HEIGHT, 32'd1);
		write_reg(REG_ORIGIN_X, 32'd8191);
		write_reg(REG_ORIGIN_Y, 32'd8191);
		run_polylines(130);
		drain();
		write_reg(REG_SCALE, 32'd0);
		write_reg(REG_VIEW_WIDTH, 32'd1);
		write_reg(REG_VIEW_HEIGHT, 32'd8191);
		run_polylines(40);
		drain();
		for (int p = 0; p < 3; p++) begin
			write_reg(REG_SCALE, $urandom_range(1, 24'hffffff));
			write_reg(REG_OFFSET_X, $urandom);
			write_reg(REG_OFFSET_Y, $urandom);
			write_reg(REG_VIEW_WIDTH, $urandom_range(1, 8191));
			write_reg(REG_VIEW_HEIGHT, $urandom_range(1, 8191));
			write_reg(REG_ORIGIN_X, $urandom_range(0, 8191));
			write_reg(REG_ORIGIN_Y, $urandom_range(0, 8191));
			write_reg(REG_WRAP_REJECT, $urandom_range(0, 1));
			run_polylines(130);
			drain();
		end
	endtask

	task automatic test_unstalled();
		quiet = 1'b1;
		write_reg(REG_SCALE, 32'h10000);
		write_reg(REG_OFFSET_X, 32'h0);
		write_reg(REG_OFFSET_Y, 32'h0);
		write_reg(REG_VIEW_WIDTH, 32'd640);
		write_reg(REG_VIEW_HEIGHT, 32'd480);
		write_reg(REG_ORIGIN_X, 32'd0);
		write_reg(REG_ORIGIN_Y, 32'd0);
		write_reg(REG_WRAP_REJECT, 32'd0);
		run_polylines(130);
		drain();
	endtask

	// result side: random stall bursts, none once the run goes quiet
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 17);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		segment_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = m_axis_tdata;
			if (expected_segs.size() == 0) begin
				errors++;
				if (mismatches++ < 10)
					$display("unexpected segment %0d,%0d -> %0d,%0d", got.start_x,
						got.start_y, got.end_x, got.end_y);
			end else begin
				want = expected_segs.pop_front();
				if (got.start_x !== want.start_x || got.start_y !== want.start_y ||
						got.end_x !== want.end_x || got.end_y !== want.end_y) begin
					errors++;
					if (mismatches++ < 10)
						$display("segment mismatch: exp %0d,%0d -> %0d,%0d got %0d,%0d -> %0d,%0d",
							want.start_x, want.start_y, want.end_x, want.end_y,
							got.start_x, got.start_y, got.end_x, got.end_y);
				end
			end
		end
	end

	// watchdog on cycles with no transfer at either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("tb: FAIL");
			$finish;
		end
	end

	initial begin
		sh_scale = 24'h10000;
		sh_off_x = 0;
		sh_off_y = 0;
		sh_width = 1024;
		sh_height = 1024;
		sh_org_x = 0;
		sh_org_y = 0;
		sh_wrap = 1'b0;
		last_px = 0;
		last_py = 0;
		last_valid = 1'b0;
		last_map_x = '0;
		last_map_y = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_wrap_reject();
		test_config_sweep();
		test_unstalled();
		if (errors == 0 && expected_segs.size() == 0)
			$display("tb: PASS");
		else
			$display("tb: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/pvc_pkg.sv
hw/rtl/pvc_div.sv
hw/rtl/pvc_dp.sv
hw/rtl/pvc_ctrl.sv
hw/rtl/polyline_viewport_clipper_core.sv
test/tb.sv
